// ----- design/tel_pkg.sv -----
package tel_pkg;

    localparam int unsigned LineCapacityDefault = 64;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_Y  = 8'h59;
    localparam logic [7:0] CH_LO_Y  = 8'h79;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    localparam logic [15:0] FRAME_WIDTH_RST  = 16'd640;
    localparam logic [15:0] FRAME_HEIGHT_RST = 16'd480;
    localparam logic [15:0] CENTER_X_RST     = 16'd320;
    localparam logic [15:0] CENTER_Y_RST     = 16'd240;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_CENTER_X     = 2'd2,
        REG_CENTER_Y     = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_X     = 3'd1,
        PH_Y     = 3'd2,
        PH_ZFLAG = 3'd3,
        PH_ZDONE = 3'd4,
        PH_DEAD  = 3'd5,
        PH_YEND  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        NS_BLANK  = 2'd0,
        NS_DIGITS = 2'd1,
        NS_STOP   = 2'd2
    } t_num_stage;

    typedef struct packed {
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [15:0] center_x;
        logic [15:0] center_y;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] err_x;
        logic signed [15:0] err_y;
        logic               valid_res;
    } t_result;

endpackage

// ----- design/tel_if.sv -----
interface tel_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

interface tel_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] err_x;
    logic signed [15:0] err_y;
    logic               valid_res;

    modport source (output valid, output err_x, output err_y, output valid_res, input ready);
    modport sink (input valid, input err_x, input err_y, input valid_res, output ready);
endinterface

interface tel_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/tel_cfg_regs.sv -----
module tel_cfg_regs
    import tel_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tel_cfg_if.sink    i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                REG_FRAME_WIDTH:  n_cfg.frame_width  = i_cfg.data;
                REG_FRAME_HEIGHT: n_cfg.frame_height = i_cfg.data;
                REG_CENTER_X:     n_cfg.center_x     = i_cfg.data;
                REG_CENTER_Y:     n_cfg.center_y     = i_cfg.data;
                default:          n_cfg              = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= FRAME_WIDTH_RST;
            r_cfg.frame_height <= FRAME_HEIGHT_RST;
            r_cfg.center_x     <= CENTER_X_RST;
            r_cfg.center_y     <= CENTER_Y_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- design/tel_parser.sv -----
module tel_parser
    import tel_pkg::*;
#(
    parameter int unsigned LINE_CAPACITY = LineCapacityDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_ch,
    input  t_cfg       i_cfg,
    output logic       o_has_res,
    output t_result    o_res
);

    localparam int unsigned KW = $clog2(LINE_CAPACITY);
    localparam logic [KW-1:0] KEEP_MAX = KW'(LINE_CAPACITY - 1);

    typedef struct packed {
        t_num_stage  stage;
        logic        neg;
        logic [15:0] value;
    } t_num;

    logic [KW-1:0] r_kept, n_kept;
    t_phase        r_phase, n_phase;
    t_num_stage    r_stage, n_stage;
    logic          r_neg, n_neg;
    logic [15:0]   r_x, n_x;
    logic [15:0]   r_y, n_y;
    logic          r_flag, n_flag;

    t_num          fed;
    logic [15:0]   y_fin;

    function automatic t_num num_feed(t_num_stage stage, logic neg, logic [15:0] v,
                                      logic [7:0] c);
        t_num   r;
        logic   digit;
        digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        r.stage = stage;
        r.neg   = neg;
        r.value = v;
        unique case (stage)
            NS_BLANK: begin
                if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
                    r.stage = NS_BLANK;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    r.neg   = (c == CH_MINUS);
                    r.stage = NS_DIGITS;
                end else if (digit) begin
                    r.value = {12'd0, c[3:0]};
                    r.stage = NS_DIGITS;
                end else begin
                    r.stage = NS_STOP;
                end
            end
            NS_DIGITS: begin
                if (digit) begin
                    r.value = (v << 3) + (v << 1) + {12'd0, c[3:0]};
                end else begin
                    r.stage = NS_STOP;
                end
            end
            default: r.stage = stage;
        endcase
        return r;
    endfunction

    always_comb begin
        priority case (r_phase)
            PH_X:    fed = num_feed(r_stage, r_neg, r_x, i_ch);
            default: fed = num_feed(r_stage, r_neg, r_y, i_ch);
        endcase
    end

    always_comb begin
        n_kept  = r_kept;
        n_phase = r_phase;
        n_stage = r_stage;
        n_neg   = r_neg;
        n_x     = r_x;
        n_y     = r_y;
        n_flag  = r_flag;
        if (i_ch == CH_LF) begin
            n_kept  = '0;
            n_phase = PH_START;
            n_stage = NS_BLANK;
            n_neg   = 1'b0;
            n_x     = '0;
            n_y     = '0;
            n_flag  = 1'b0;
        end else if (i_ch != CH_CR && r_kept < KEEP_MAX) begin
            n_kept = r_kept + KW'(1);
            unique case (r_phase)
                PH_START: begin
                    n_phase = (i_ch == CH_UP_X || i_ch == CH_LO_X) ? PH_X : PH_DEAD;
                end
                PH_X: begin
                    if (i_ch == CH_UP_Y || i_ch == CH_LO_Y) begin
                        n_x     = r_neg ? (~r_x + 16'd1) : r_x;
                        n_stage = NS_BLANK;
                        n_neg   = 1'b0;
                        n_phase = PH_Y;
                    end else if (i_ch == CH_NUL) begin
                        n_phase = PH_DEAD;
                    end else begin
                        n_stage = fed.stage;
                        n_neg   = fed.neg;
                        n_x     = fed.value;
                    end
                end
                PH_Y: begin
                    if (i_ch == CH_UP_Z || i_ch == CH_LO_Z || i_ch == CH_NUL) begin
                        n_y     = r_neg ? (~r_y + 16'd1) : r_y;
                        n_stage = NS_BLANK;
                        n_neg   = 1'b0;
                        n_phase = (i_ch == CH_NUL) ? PH_YEND : PH_ZFLAG;
                    end else begin
                        n_stage = fed.stage;
                        n_neg   = fed.neg;
                        n_y     = fed.value;
                    end
                end
                PH_ZFLAG: begin
                    n_flag  = (i_ch == CH_ONE);
                    n_phase = PH_ZDONE;
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // Result for a line end, formed from the state before the update.
    always_comb begin
        y_fin     = (r_phase == PH_Y && r_neg) ? (~r_y + 16'd1) : r_y;
        o_has_res = (i_ch == CH_LF) &&
                    (r_phase == PH_ZFLAG || r_phase == PH_ZDONE ||
                     r_phase == PH_Y || r_phase == PH_YEND);
        o_res     = '0;
        if (r_phase == PH_ZFLAG || r_phase == PH_ZDONE) begin
            o_res.err_x     = r_x;
            o_res.err_y     = y_fin;
            o_res.valid_res = (r_phase == PH_ZDONE) && r_flag;
        end else if (r_x < i_cfg.frame_width && y_fin < i_cfg.frame_height) begin
            o_res.err_x     = r_x - i_cfg.center_x;
            o_res.err_y     = y_fin - i_cfg.center_y;
            o_res.valid_res = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept  <= '0;
            r_phase <= PH_START;
            r_stage <= NS_BLANK;
            r_neg   <= 1'b0;
            r_x     <= '0;
            r_y     <= '0;
            r_flag  <= 1'b0;
        end else if (i_step) begin
            r_kept  <= n_kept;
            r_phase <= n_phase;
            r_stage <= n_stage;
            r_neg   <= n_neg;
            r_x     <= n_x;
            r_y     <= n_y;
            r_flag  <= n_flag;
        end
    end

endmodule

// ----- design/target_error_line_parser.sv -----
// Target error line parser.
// Characters enter on the byte channel, one per transfer. Lines of the form
// X<num>Y<num>[Z<flag>] end with LF; CR is skipped and only the first
// LINE_CAPACITY-1 other characters of a line are used. For each LF that
// closes a line with both X and Y, one result transfer carries err_x, err_y
// and valid_res; other characters produce no result.
// The configuration channel is always ready and writes frame_width,
// frame_height, center_x and center_y by index 0 to 3; write only when idle.
// Throughput is one character per cycle unless the result channel stalls.
// A character waits in the input register until the parser advances; then
// the parser state and the result register update from it.
// When the receiver stalls, one result waits in the output register while
// further characters are still taken into the input register; only an LF
// that yields a result, behind an untaken result, holds the byte channel.
// Synchronous active-low reset empties both registers, restores the
// configuration defaults and returns the parser to the start of a line.
module target_error_line_parser
    import tel_pkg::*;
#(
    parameter int unsigned LINE_CAPACITY = LineCapacityDefault
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tel_byte_if.sink i_in,
    tel_cfg_if.sink  i_cfg,
    tel_res_if.source o_res
);

    t_cfg       cfg;
    logic       has_res;
    t_result    res;
    logic       advance;

    logic       r_ch_vld;
    logic [7:0] r_ch;
    logic       r_out_vld;
    t_result    r_out;

    tel_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    tel_parser #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_ch      (r_ch),
        .i_cfg     (cfg),
        .o_has_res (has_res),
        .o_res     (res)
    );

    assign advance    = r_ch_vld && (!has_res || !r_out_vld || o_res.ready);
    assign i_in.ready = !r_ch_vld || advance;

    assign o_res.valid     = r_out_vld;
    assign o_res.err_x     = r_out.err_x;
    assign o_res.err_y     = r_out.err_y;
    assign o_res.valid_res = r_out.valid_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_ch_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_ch <= i_in.ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && has_res) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_res) begin
            r_out <= res;
        end
    end

endmodule

// ----- tb/tb.sv -----
module tb;
    import tel_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LINE_CAP = LineCapacityDefault;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int CHARS_PER_PHASE = 230;
    localparam int NUM_PHASES = 6;
    localparam int DRAIN_CYCLES = 4;
    localparam int END_CYCLES = 10;

    typedef enum int {
        LINE_OLD,
        LINE_NEW,
        LINE_LONG,
        LINE_BROKEN,
        LINE_NOISE
    } t_line_kind;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic [7:0]  in_ch = 8'h00;
    logic        res_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;

    tel_byte_if byte_if ();
    tel_cfg_if  cfg_if ();
    tel_res_if  res_if ();

    assign byte_if.valid = in_valid;
    assign byte_if.ch    = in_ch;
    assign res_if.ready  = res_ready;
    assign cfg_if.valid  = cfg_valid;
    assign cfg_if.index  = cfg_index;
    assign cfg_if.data   = cfg_data;

    target_error_line_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // Shadow of the parser: configuration and the state of the current line.
    t_cfg        cfg_shadow = '{FRAME_WIDTH_RST, FRAME_HEIGHT_RST, CENTER_X_RST, CENTER_Y_RST};
    int unsigned kept_chars = 0;
    t_phase      line_phase = PH_START;
    t_num_stage  num_stage = NS_BLANK;
    logic        num_neg = 1'b0;
    logic [15:0] x_coord = 16'd0;
    logic [15:0] y_coord = 16'd0;
    logic        flag_one = 1'b0;

    logic [7:0] pending_chars[$];
    t_result    expected_errors[$];

    int mismatches = 0;
    int cycle_count = 0;
    int idle_pct = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_used = 1'b0;
    t_result got;
    t_result want;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [15:0] feed_number(input logic [15:0] v, input logic [7:0] c);
        logic is_digit;
        logic [15:0] nv;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        nv = v;
        if (num_stage == NS_BLANK) begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
                nv = v;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
                num_neg = (c == CH_MINUS);
                num_stage = NS_DIGITS;
            end else if (is_digit) begin
                nv = {8'd0, c - CH_ZERO};
                num_stage = NS_DIGITS;
            end else begin
                num_stage = NS_STOP;
            end
        end else if (num_stage == NS_DIGITS) begin
            if (is_digit) begin
                nv = v * 16'd10 + {8'd0, c - CH_ZERO};
            end else begin
                num_stage = NS_STOP;
            end
        end
        return nv;
    endfunction

    function automatic logic [15:0] finish_number(input logic [15:0] v);
        logic [15:0] nv;
        nv = num_neg ? 16'd0 - v : v;
        num_stage = NS_BLANK;
        num_neg = 1'b0;
        return nv;
    endfunction

    function automatic void clear_line();
        kept_chars = 0;
        line_phase = PH_START;
        num_stage = NS_BLANK;
        num_neg = 1'b0;
        x_coord = 16'd0;
        y_coord = 16'd0;
        flag_one = 1'b0;
    endfunction

    function automatic void accept_char(input logic [7:0] c);
        t_result r;
        r = '0;
        if (c == CH_LF) begin
            if (line_phase == PH_Y) begin
                y_coord = finish_number(y_coord);
            end
            if (line_phase == PH_ZFLAG || line_phase == PH_ZDONE) begin
                r.err_x = x_coord;
                r.err_y = y_coord;
                r.valid_res = (line_phase == PH_ZDONE) && flag_one;
                expected_errors.push_back(r);
            end else if (line_phase == PH_Y || line_phase == PH_YEND) begin
                if (x_coord < cfg_shadow.frame_width && y_coord < cfg_shadow.frame_height) begin
                    r.err_x = x_coord - cfg_shadow.center_x;
                    r.err_y = y_coord - cfg_shadow.center_y;
                    r.valid_res = 1'b1;
                end
                expected_errors.push_back(r);
            end
            clear_line();
        end else if (c != CH_CR && kept_chars < LINE_CAP - 1) begin
            kept_chars++;
            case (line_phase)
                PH_START: begin
                    line_phase = (c == CH_UP_X || c == CH_LO_X) ? PH_X : PH_DEAD;
                end
                PH_X: begin
                    if (c == CH_UP_Y || c == CH_LO_Y) begin
                        x_coord = finish_number(x_coord);
                        line_phase = PH_Y;
                    end else if (c == CH_NUL) begin
                        line_phase = PH_DEAD;
                    end else begin
                        x_coord = feed_number(x_coord, c);
                    end
                end
                PH_Y: begin
                    if (c == CH_UP_Z || c == CH_LO_Z) begin
                        y_coord = finish_number(y_coord);
                        line_phase = PH_ZFLAG;
                    end else if (c == CH_NUL) begin
                        y_coord = finish_number(y_coord);
                        line_phase = PH_YEND;
                    end else begin
                        y_coord = feed_number(y_coord, c);
                    end
                end
                PH_ZFLAG: begin
                    flag_one = (c == CH_ONE);
                    line_phase = PH_ZDONE;
                end
                default: begin
                end
            endcase
        end
    endfunction

    // Byte driver: the valid is held until the transfer happens.
    always @(posedge i_clk) begin
        if (in_valid && byte_if.ready) begin
            accept_char(in_ch);
            void'(pending_chars.pop_front());
        end
        if (in_valid && !byte_if.ready) begin
            in_valid <= 1'b1;
        end else if (send_gap > 0) begin
            send_gap--;
            in_valid <= 1'b0;
        end else if (pending_chars.size() > 0 && idle_pct > 0
                     && $urandom_range(0, 99) < idle_pct) begin
            send_gap = $urandom_range(1, 9) - 1;
            in_valid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
            in_valid <= 1'b1;
            in_ch <= pending_chars[0];
        end else begin
            in_valid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (res_if.valid && res_ready) begin
            got.err_x = res_if.err_x;
            got.err_y = res_if.err_y;
            got.valid_res = res_if.valid_res;
            if (expected_errors.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: x=%0d y=%0d valid=%0b",
                             got.err_x, got.err_y, got.valid_res);
                end
            end else begin
                want = expected_errors.pop_front();
                if (got.err_x !== want.err_x || got.err_y !== want.err_y
                    || got.valid_res !== want.valid_res) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected x=%0d y=%0d valid=%0b, got x=%0d y=%0d valid=%0b",
                                 want.err_x, want.err_y, want.valid_res,
                                 got.err_x, got.err_y, got.valid_res);
                    end
                end
            end
        end
        if (hold_left != 0) begin
            res_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            res_ready <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            recv_gap = $urandom_range(1, 9) - 1;
            res_ready <= 1'b0;
        end else begin
            res_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_char(input logic [7:0] c);
        if ($urandom_range(0, 19) == 0) begin
            pending_chars.push_back(CH_CR);
        end
        pending_chars.push_back(c);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i]);
        end
    endtask

    task automatic push_case(input logic [7:0] upper, input logic [7:0] lower);
        push_char($urandom_range(0, 1) ? upper : lower);
    endtask

    task automatic push_number(input logic [15:0] frame);
        int unsigned v;
        int unsigned lim;
        int sel;
        int nblank;
        lim = 32'(frame);
        sel = $urandom_range(0, 3);
        nblank = (sel == 0) ? $urandom_range(1, 2) : 0;
        for (int i = 0; i < nblank; i++) begin
            case ($urandom_range(0, 3))
                0: push_char(CH_SPACE);
                1: push_char(CH_TAB);
                2: push_char(CH_VT);
                default: push_char(CH_FF);
            endcase
        end
        sel = $urandom_range(0, 7);
        if (sel == 0) begin
            push_char(CH_PLUS);
        end else if (sel == 1) begin
            push_char(CH_MINUS);
        end
        if ($urandom_range(0, 19) == 0) begin
            return;
        end
        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
            v = $urandom_range(0, lim);
        end else if (sel == 6) begin
            v = $urandom_range(0, 1) ? lim : lim - 1;
        end else if (sel == 7) begin
            v = 0;
        end else if (sel == 8) begin
            v = $urandom_range(0, 65535);
        end else begin
            v = $urandom_range(0, 99999999);
        end
        if ($urandom_range(0, 9) == 0) begin
            push_char(CH_ZERO);
        end
        push_text($sformatf("%0d", v));
        if ($urandom_range(0, 9) == 0) begin
            push_char($urandom_range(0, 1) ? CH_SPACE : 8'h61);
        end
    endtask

    task automatic push_coords();
        push_case(CH_UP_X, CH_LO_X);
        push_number(cfg_shadow.frame_width);
        push_case(CH_UP_Y, CH_LO_Y);
        push_number(cfg_shadow.frame_height);
    endtask

    task automatic push_flag();
        int sel;
        push_case(CH_UP_Z, CH_LO_Z);
        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
            push_char(CH_ONE);
        end else if (sel <= 7) begin
            push_char(CH_ZERO);
        end else if (sel == 8) begin
            push_char(8'($urandom_range(11, 255)));
        end
    endtask

    task automatic push_line();
        t_line_kind kind;
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 40) kind = LINE_OLD;
        else if (sel < 75) kind = LINE_NEW;
        else if (sel < 83) kind = LINE_LONG;
        else if (sel < 93) kind = LINE_BROKEN;
        else kind = LINE_NOISE;
        case (kind)
            LINE_OLD: begin
                push_coords();
            end
            LINE_NEW: begin
                push_coords();
                push_flag();
            end
            LINE_LONG: begin
                push_case(CH_UP_X, CH_LO_X);
                push_number(cfg_shadow.frame_width);
                n = $urandom_range(0, 1) ? $urandom_range(50, 66) : 0;
                for (int i = 0; i < n; i++) begin
                    push_char(8'(CH_ZERO + $urandom_range(0, 9)));
                end
                push_case(CH_UP_Y, CH_LO_Y);
                push_number(cfg_shadow.frame_height);
                if ($urandom_range(0, 1)) begin
                    push_flag();
                end
                n = $urandom_range(40, 70);
                for (int i = 0; i < n; i++) begin
                    push_char(8'($urandom_range(11, 255)));
                end
            end
            LINE_BROKEN: begin
                case ($urandom_range(0, 5))
                    0: begin
                        push_char($urandom_range(0, 1) ? CH_SPACE : CH_UP_Y);
                        push_coords();
                    end
                    1: begin
                        push_case(CH_UP_X, CH_LO_X);
                        push_number(cfg_shadow.frame_width);
                        push_char(CH_NUL);
                        push_case(CH_UP_Y, CH_LO_Y);
                        push_number(cfg_shadow.frame_height);
                    end
                    2: begin
                        push_coords();
                        push_char(CH_NUL);
                        push_flag();
                    end
                    3: begin
                        push_case(CH_UP_X, CH_LO_X);
                        push_number(cfg_shadow.frame_width);
                    end
                    4: begin
                        push_case(CH_UP_X, CH_LO_X);
                        push_case(CH_UP_Y, CH_LO_Y);
                        if ($urandom_range(0, 1)) begin
                            push_case(CH_UP_Z, CH_LO_Z);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    pending_chars.push_back(8'($urandom_range(0, 255)));
                end
            end
        endcase
        pending_chars.push_back(CH_LF);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  cfg_shadow.frame_width = val;
            REG_FRAME_HEIGHT: cfg_shadow.frame_height = val;
            REG_CENTER_X:     cfg_shadow.center_x = val;
            default:          cfg_shadow.center_y = val;
        endcase
    endtask

    task automatic set_frame(input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] cx, input logic [15:0] cy);
        write_cfg(REG_FRAME_WIDTH, w);
        write_cfg(REG_FRAME_HEIGHT, h);
        write_cfg(REG_CENTER_X, cx);
        write_cfg(REG_CENTER_Y, cy);
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0 || expected_errors.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int target;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_pct = 15;

        push_text("X639Y479\n");
        push_text("x640y-1\n");
        push_text("X \t-5y+7z1\n");
        push_text("X1Y2Z\n");
        push_text("X9Y9Z0\n");
        push_text("Q1Y2\n");
        push_text("X5");
        pending_chars.push_back(CH_NUL);
        push_text("Y3\n");
        push_text("X5Y3");
        pending_chars.push_back(CH_NUL);
        push_text("Z1\n");
        push_text("X99999Y\n");

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            case (ph)
                0: begin
                end
                1: set_frame(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
                2: set_frame(16'd1, 16'd1, 16'hFFFF, 16'hFFFF);
                3: set_frame(16'($urandom_range(1, 1000)), 16'($urandom_range(1, 1000)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                4: set_frame(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                default: set_frame(FRAME_WIDTH_RST, FRAME_HEIGHT_RST,
                                   CENTER_X_RST, CENTER_Y_RST);
            endcase
            case (ph)
                0: idle_pct = 15;
                1: idle_pct = 30;
                2: idle_pct = 5;
                3: idle_pct = 50;
                4: idle_pct = 20;
                default: idle_pct = 0;
            endcase
            if (ph == 1) begin
                hold_req = 1'b1;
            end
            target = pending_chars.size() + CHARS_PER_PHASE;
            while (pending_chars.size() < target) begin
                push_line();
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
